### src/llba_pkg.sv
// shared constants, types and state codes for the least-loaded bin assigner
`timescale 1ns / 1ps
`default_nettype none
package llba_pkg;

   // built bin count and derived widths
   localparam int MAX_BINS = 16;
   localparam int IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int CNT_W = $clog2(MAX_BINS + 1);

   // word field widths
   localparam int WEIGHT_W = 16;
   localparam int BIN_NUM_W = 5;
   localparam int LOAD_W = 32;
   localparam int NUM_BINS_W = 5;

   // register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [0:0] CSR_IDX_NUM_BINS = 1'b0;
   localparam logic [NUM_BINS_W-1:0] NUM_BINS_RESET = NUM_BINS_W'(16);

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_UPDATE
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic load_item;
      logic issue;
      logic commit;
   } ctrl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic scan_last;
      logic out_free;
   } dp_status_type;

endpackage
`default_nettype wire

### src/llba_ctrl.sv
// sequencer that steps one word through load, scan, drain and update
`timescale 1ns / 1ps
`default_nettype none
module llba_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  llba_pkg::dp_status_type status,
   output llba_pkg::ctrl_cmd_type  cmd
);
   import llba_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.issue = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

### src/llba_datapath.sv
// bin load store, scan compare, saturating add and result register
`timescale 1ns / 1ps
`default_nettype none
module llba_datapath (
   input  wire                               clock,
   input  wire                               reset,
   input  wire [llba_pkg::NUM_BINS_W-1:0]    num_bins,
   input  wire                               req_new_set,
   input  wire [llba_pkg::WEIGHT_W-1:0]      req_weight,
   input  llba_pkg::ctrl_cmd_type            cmd,
   output llba_pkg::dp_status_type           status,
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output logic [llba_pkg::BIN_NUM_W-1:0]    rsp_bin_number,
   output logic [llba_pkg::LOAD_W-1:0]       rsp_bin_load
);
   import llba_pkg::*;

   // bin load memory with per-entry valid bits
   logic [LOAD_W-1:0]   mem [MAX_BINS];
   logic [MAX_BINS-1:0] valid_ff, valid_in;

   // per-word registers
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [IDX_W-1:0]    end_ff, end_in;
   logic                first_ff, first_in;
   logic [WEIGHT_W-1:0] weight_ff;

   // read pipeline
   logic [LOAD_W-1:0]   rd_data_ff;
   logic                rd_live_ff;
   logic                rd_valid_ff;
   logic                rd_first_ff;
   logic [IDX_W-1:0]    rd_idx_ff;

   // running minimum
   logic [LOAD_W-1:0]   best_ff;
   logic [IDX_W-1:0]    pick_ff;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [BIN_NUM_W-1:0] rsp_bin_number_ff;
   logic [LOAD_W-1:0]    rsp_bin_load_ff;

   logic [CNT_W-1:0]    used;
   logic [CNT_W-1:0]    eff_cnt;
   logic                direct;
   logic [LOAD_W-1:0]   rd_load;
   logic [LOAD_W:0]     sum;
   logic [LOAD_W-1:0]   sat_load;

   // bins in use, clamped to one through the built count
   always_comb begin
      if (num_bins == '0) begin
         used = CNT_W'(1);
      end else if (32'(num_bins) > 32'(MAX_BINS)) begin
         used = CNT_W'(MAX_BINS);
      end else begin
         used = CNT_W'(num_bins);
      end
   end

   // scan setup when a word is taken
   always_comb begin
      eff_cnt = req_new_set ? '0 : count_ff;
      direct = (eff_cnt < used);
      count_in = count_ff;
      idx_in = idx_ff;
      end_in = end_ff;
      first_in = first_ff;
      valid_in = valid_ff;
      if (cmd.load_item) begin
         if (req_new_set) begin
            valid_in = '0;
         end
         first_in = 1'b1;
         if (direct) begin
            idx_in = eff_cnt[IDX_W-1:0];
            end_in = eff_cnt[IDX_W-1:0];
            count_in = eff_cnt + CNT_W'(1);
         end else begin
            idx_in = '0;
            end_in = IDX_W'(used - CNT_W'(1));
            count_in = eff_cnt;
         end
      end else if (cmd.issue) begin
         first_in = 1'b0;
         idx_in = idx_ff + IDX_W'(1);
      end
      if (cmd.commit) begin
         valid_in[pick_ff] = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
         rd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
         rd_valid_ff <= cmd.issue;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      end_ff <= end_in;
      first_ff <= first_in;
      if (cmd.load_item) begin
         weight_ff <= req_weight;
      end
   end

   // memory read and write
   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         rd_data_ff <= mem[idx_ff];
         rd_live_ff <= valid_ff[idx_ff];
         rd_first_ff <= first_ff;
         rd_idx_ff <= idx_ff;
      end
      if (cmd.commit) begin
         mem[pick_ff] <= sat_load;
      end
   end

   // minimum tracking, lowest index wins a tie
   assign rd_load = rd_live_ff ? rd_data_ff : '0;

   always_ff @(posedge clock) begin
      if (rd_valid_ff && (rd_first_ff || (rd_load < best_ff))) begin
         best_ff <= rd_load;
         pick_ff <= rd_idx_ff;
      end
   end

   // saturating add
   assign sum = {1'b0, best_ff} + (LOAD_W + 1)'(weight_ff);
   assign sat_load = sum[LOAD_W] ? '1 : sum[LOAD_W-1:0];

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_bin_number_ff <= BIN_NUM_W'(pick_ff) + BIN_NUM_W'(1);
         rsp_bin_load_ff <= sat_load;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_bin_number = rsp_bin_number_ff;
   assign rsp_bin_load = rsp_bin_load_ff;

   // status back to the sequencer
   assign status.scan_last = (idx_ff == end_ff);
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   // checks
   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("result not shown after commit");

   a_commit_room: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_ready))
      else $error("commit over a pending result");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(MAX_BINS))
      else $error("placement count past bin count");

   a_set_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_item && req_new_set) |=> (valid_ff == '0))
      else $error("new set left bin loads behind");

endmodule
`default_nettype wire

### src/least_loaded_bin_assigner_top.sv
// top level: register port, sequencer and datapath of the bin assigner
//
// Greedy least-loaded scheduler. Each req word carries a job weight and a
// new_set flag; each rsp word carries the 1-based bin and its new load.
// The first bins-in-use words of a set fill bins in order, later words go
// to the lightest bin, ties to the lowest index. Loads saturate at 2^32-1.
// num_bins sits at address 0 of the register port (reset 16; 0 acts as 1).
// One word at a time: req_ready is high only while the sequencer is idle.
// A word that fills a fresh bin reads only that bin; a word that scans reads
// the bins in use in turn, one memory read per cycle, and then passes a
// drain and an update step before rsp_valid rises. The sequencer takes the
// next word in its idle state, after the last one has committed.
// The result sits in an output register, so a new word is taken while it
// waits; if rsp_ready stays low the next word stalls at its update step.
// Reset clears all bin loads, the placement count and num_bins to 16.
`timescale 1ns / 1ps
`default_nettype none
module least_loaded_bin_assigner_top (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_ready,
   input  wire                               req_new_set,
   input  wire [llba_pkg::WEIGHT_W-1:0]      req_weight,
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output logic [llba_pkg::BIN_NUM_W-1:0]    rsp_bin_number,
   output logic [llba_pkg::LOAD_W-1:0]       rsp_bin_load,
   input  wire                               psel,
   input  wire                               penable,
   input  wire                               pwrite,
   input  wire [llba_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire [llba_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [llba_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);
   import llba_pkg::*;

   logic [NUM_BINS_W-1:0] num_bins_ff;
   logic                  csr_hit;
   ctrl_cmd_type          cmd;
   dp_status_type         status;

   // register decode
   assign pready = 1'b1;
   assign csr_hit = (paddr[CSR_ADDR_W-1:2] == CSR_IDX_NUM_BINS);

   always_ff @(posedge clock) begin
      if (reset) begin
         num_bins_ff <= NUM_BINS_RESET;
      end else if (psel && penable && pwrite && pready && csr_hit) begin
         num_bins_ff <= pwdata[NUM_BINS_W-1:0];
      end
   end

   assign prdata = csr_hit ? CSR_DATA_W'(num_bins_ff) : '0;

   // sequencer
   llba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   llba_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .num_bins       (num_bins_ff),
      .req_new_set    (req_new_set),
      .req_weight     (req_weight),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_bin_number (rsp_bin_number),
      .rsp_bin_load   (rsp_bin_load)
   );

endmodule
`default_nettype wire
